### hdl/lpfd_pkg.sv
// Shared types and constants for the length-prefixed frame deframer.
// No dependencies; every module of the block imports this package.
package lpfd_pkg;

    // Header: three big-endian words (length, client id, backend id).
    localparam int unsigned HEADER_BYTES = 12;
    localparam int unsigned HDR_CNT_W    = 4;
    localparam int unsigned MAX_LEN_W    = 21;

    localparam logic [HDR_CNT_W-1:0] HDR_LEN_END    = HDR_CNT_W'(4);
    localparam logic [HDR_CNT_W-1:0] HDR_CLIENT_END = HDR_CNT_W'(8);
    localparam logic [HDR_CNT_W-1:0] HDR_LAST       = HDR_CNT_W'(HEADER_BYTES - 1);

    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = MAX_LEN_W'(65536);

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_DROP    = 2'd2
    } t_kind;

    // One result record as it travels from the parser to the output stage.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [31:0] client_tag;
        logic [31:0] server_tag;
        logic [31:0] frame_length;
        logic        last;
    } t_rec;

    // Write side of the record queue.
    typedef struct packed {
        logic wr_en;
        t_rec rec;
    } t_q_wr;

endpackage

### hdl/length_prefixed_frame_deframer.sv
// Length-prefixed frame deframer: one byte of the stream is taken per push, at a
// sustained rate of one byte per clock while full is low. Each frame starts with a
// 12-byte header of three big-endian 32-bit words (payload length, client id, backend
// id). Header bytes give no result, except the last one, which gives a drop result
// (kind 2) if the length exceeds max_payload_len, or an empty-frame result (kind 1) if
// the length is zero. Otherwise every payload byte comes out as one kind 0 result with
// both ids and the length, and last marks the final byte. After a drop the next byte
// is taken as the start of a new header. A result is written into a four-entry record
// queue at the edge that transfers its byte and then loaded into one output register;
// these let the input keep streaming while the reader stalls, and full rises only once
// all of them hold results. Write max_payload_len only while idle.
// Depends on lpfd_pkg, lpfd_front, lpfd_queue and lpfd_back.
module length_prefixed_frame_deframer
    import lpfd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // byte stream in
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           i_data_byte,
    // results out
    output logic                 empty,
    input  logic                 pop,
    output logic [1:0]           o_kind,
    output logic [7:0]           o_payload_byte,
    output logic [31:0]          o_client_tag,
    output logic [31:0]          o_server_tag,
    output logic [31:0]          o_frame_length,
    output logic                 o_last,
    // max_payload_len write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [MAX_LEN_W-1:0] i_cfg_data
);

    t_q_wr q_wr;
    t_rec  q_rec;
    t_rec  out_rec;
    logic  q_full;
    logic  q_not_empty;
    logic  q_rd_en;
    logic  out_valid;
    logic  byte_accept;

    // Transfer a byte when the queue has room for whatever it may produce.
    assign full        = q_full;
    assign byte_accept = push && !q_full;
    assign o_cfg_ready = 1'b1;

    lpfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (byte_accept),
        .i_data_byte (i_data_byte),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_q_wr      (q_wr)
    );

    lpfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (q_wr),
        .i_rd_en     (q_rd_en),
        .o_full      (q_full),
        .o_not_empty (q_not_empty),
        .o_rd_rec    (q_rec)
    );

    // Hold the oldest result until the reader pops it.
    lpfd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_not_empty (q_not_empty),
        .i_q_rec       (q_rec),
        .i_pop         (pop),
        .o_q_rd_en     (q_rd_en),
        .o_valid       (out_valid),
        .o_rec         (out_rec)
    );

    assign empty          = !out_valid;
    assign o_kind         = out_rec.kind;
    assign o_payload_byte = out_rec.payload_byte;
    assign o_client_tag   = out_rec.client_tag;
    assign o_server_tag   = out_rec.server_tag;
    assign o_frame_length = out_rec.frame_length;
    assign o_last         = out_rec.last;

    // Drop and empty-frame results are always the final result of their frame and carry a zero payload byte.
    a_non_payload_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_kind != KIND_PAYLOAD)) |-> o_last && (o_payload_byte == 8'd0))
        else $error("non-payload result without last or with a payload byte");

endmodule

### hdl/lpfd_front.sv
// Header parser and payload counter of the frame deframer.
// Depends on lpfd_pkg; feeds records into lpfd_queue.
module lpfd_front
    import lpfd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_cfg_we,
    input  logic [MAX_LEN_W-1:0] i_cfg_data,
    output t_q_wr                o_q_wr
);

    logic                 r_in_payload, n_in_payload;
    logic [HDR_CNT_W-1:0] r_hdr_cnt, n_hdr_cnt;
    logic [31:0]          r_len, n_len;
    logic [31:0]          r_client, n_client;
    logic [31:0]          r_server, n_server;
    logic [31:0]          r_left, n_left;
    logic [MAX_LEN_W-1:0] r_max_len;

    always_comb begin
        n_in_payload = r_in_payload;
        n_hdr_cnt    = r_hdr_cnt;
        n_len        = r_len;
        n_client     = r_client;
        n_server     = r_server;
        n_left       = r_left;
        o_q_wr       = '0;
        o_q_wr.rec.client_tag   = r_client;
        o_q_wr.rec.server_tag   = r_server;
        o_q_wr.rec.frame_length = r_len;
        o_q_wr.rec.kind         = KIND_PAYLOAD;
        if (i_accept) begin
            if (r_in_payload) begin
                n_left = r_left - 32'd1;
                o_q_wr.wr_en            = 1'b1;
                o_q_wr.rec.payload_byte = i_data_byte;
                o_q_wr.rec.last         = (r_left == 32'd1);
                if (r_left == 32'd1) begin
                    n_in_payload = 1'b0;
                end
            end else begin
                if (r_hdr_cnt < HDR_LEN_END) begin
                    n_len = {r_len[23:0], i_data_byte};
                end else if (r_hdr_cnt < HDR_CLIENT_END) begin
                    n_client = {r_client[23:0], i_data_byte};
                end else begin
                    n_server = {r_server[23:0], i_data_byte};
                end
                n_hdr_cnt = r_hdr_cnt + 1'b1;
                if (r_hdr_cnt == HDR_LAST) begin
                    n_hdr_cnt             = '0;
                    o_q_wr.rec.server_tag = n_server;
                    o_q_wr.rec.last       = 1'b1;
                    if (r_len > {{(32-MAX_LEN_W){1'b0}}, r_max_len}) begin
                        o_q_wr.wr_en    = 1'b1;
                        o_q_wr.rec.kind = KIND_DROP;
                    end else if (r_len == 32'd0) begin
                        o_q_wr.wr_en    = 1'b1;
                        o_q_wr.rec.kind = KIND_EMPTY;
                    end else begin
                        n_left       = r_len;
                        n_in_payload = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload <= 1'b0;
            r_hdr_cnt    <= '0;
            r_max_len    <= MAX_LEN_RESET;
        end else begin
            r_in_payload <= n_in_payload;
            r_hdr_cnt    <= n_hdr_cnt;
            if (i_cfg_we) begin
                r_max_len <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len    <= n_len;
        r_client <= n_client;
        r_server <= n_server;
        r_left   <= n_left;
    end

    // Payload mode only starts at a header boundary and always has bytes left.
    a_payload_at_boundary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> (r_hdr_cnt == '0) && (r_left != 32'd0))
        else $error("payload mode with header count or zero byte count");

    a_hdr_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_cnt <= HDR_LAST)
        else $error("header count past header end");

endmodule

### hdl/lpfd_queue.sv
// Short record queue between parser and output stage.
// Depends on lpfd_pkg for the record and write-port types.
module lpfd_queue
    import lpfd_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_q_wr i_wr,
    input  logic  i_rd_en,
    output logic  o_full,
    output logic  o_not_empty,
    output t_rec  o_rd_rec
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_rec               mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_cnt;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full      = (r_cnt == CNT_W'(DEPTH));
    assign o_not_empty = (r_cnt != '0);
    assign o_rd_rec    = mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr.wr_en) begin
            mem[r_wr_ptr] <= i_wr.rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_wr.wr_en) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_rd_en) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({i_wr.wr_en, i_rd_en})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.wr_en |-> !o_full)
        else $error("record written into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd_en |-> o_not_empty)
        else $error("record read from an empty queue");

endmodule

### hdl/lpfd_back.sv
// Output register stage of the frame deframer: holds the oldest result.
// Depends on lpfd_pkg; drains lpfd_queue.
module lpfd_back
    import lpfd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_not_empty,
    input  t_rec i_q_rec,
    input  logic i_pop,
    output logic o_q_rd_en,
    output logic o_valid,
    output t_rec o_rec
);

    logic r_valid;
    t_rec r_rec;
    logic load;

    // Refill whenever the register is free or being taken this cycle.
    assign load      = i_q_not_empty && (!r_valid || i_pop);
    assign o_q_rd_en = load;
    assign o_valid   = r_valid;
    assign o_rec     = r_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rec <= i_q_rec;
        end
    end

endmodule

### sim/testbench.sv
// Self-checking testbench for length_prefixed_frame_deframer: byte stream in, checked results out.
// Depends on lpfd_pkg (result kinds, header size, register width) and the deframer RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lpfd_pkg::*;

    // DUT connections; every input holds a known value from time zero
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 push        = 1'b0;
    logic                 full;
    logic [7:0]           i_data_byte = '0;
    logic                 empty;
    logic                 pop         = 1'b0;
    logic [1:0]           o_kind;
    logic [7:0]           o_payload_byte;
    logic [31:0]          o_client_tag;
    logic [31:0]          o_server_tag;
    logic [31:0]          o_frame_length;
    logic                 o_last;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [MAX_LEN_W-1:0] i_cfg_data  = '0;

    // Shadow copy of the deframer: register, header collector and payload counter
    logic [MAX_LEN_W-1:0] max_len     = MAX_LEN_RESET;
    logic                 in_body     = 1'b0;
    int unsigned          hdr_seen    = 0;
    logic [31:0]          len_word    = '0;
    logic [31:0]          client_word = '0;
    logic [31:0]          server_word = '0;
    logic [31:0]          bytes_to_go = '0;

    // Results the deframer owes us, oldest first
    t_rec pending_results[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int errors        = 0;
    int bytes_pushed  = 0;
    int n_payload     = 0;
    int n_empty       = 0;
    int n_drop        = 0;

    length_prefixed_frame_deframer u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_data_byte    (i_data_byte),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_payload_byte (o_payload_byte),
        .o_client_tag   (o_client_tag),
        .o_server_tag   (o_server_tag),
        .o_frame_length (o_frame_length),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case a handshake never completes
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Advance the shadow deframer by one accepted byte and queue any result it owes.
    task automatic deframe_byte(input logic [7:0] b);
        t_rec r;
        r.payload_byte = 8'h00;
        if (in_body) begin
            // Payload byte: one result per byte, last on the final one
            bytes_to_go    = bytes_to_go - 32'd1;
            r.kind         = KIND_PAYLOAD;
            r.payload_byte = b;
            r.client_tag   = client_word;
            r.server_tag   = server_word;
            r.frame_length = len_word;
            r.last         = (bytes_to_go == 32'd0);
            if (r.last)
                in_body = 1'b0;
            pending_results.push_back(r);
            return;
        end
        // Header byte: shift into the word it belongs to, big-endian
        if (hdr_seen < 4)
            len_word = {len_word[23:0], b};
        else if (hdr_seen < 8)
            client_word = {client_word[23:0], b};
        else
            server_word = {server_word[23:0], b};
        hdr_seen++;
        if (hdr_seen < HEADER_BYTES)
            return;
        hdr_seen       = 0;
        r.client_tag   = client_word;
        r.server_tag   = server_word;
        r.frame_length = len_word;
        r.last         = 1'b1;
        // Compare against the full 21-bit register; the upper length bits still count
        if (len_word > {11'd0, max_len}) begin
            r.kind = KIND_DROP;
            pending_results.push_back(r);
        end else if (len_word == 32'd0) begin
            r.kind = KIND_EMPTY;
            pending_results.push_back(r);
        end else begin
            bytes_to_go = len_word;
            in_body     = 1'b1;
        end
    endtask

    // Called at a falling edge; returns at a falling edge with push left high so
    // back-to-back transfers need no second assignment in the same step.
    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push        <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (full);
        deframe_byte(b);
        bytes_pushed++;
        @(negedge i_clk);
    endtask

    // Hold the sender until every owed result has been taken, then let the
    // pipeline settle so a late header byte has been folded in as well.
    task automatic wait_drained();
        push <= 1'b0;
        @(negedge i_clk);
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_max_len(input logic [MAX_LEN_W-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        max_len = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_header(input logic [31:0] len, input logic [31:0] client,
                               input logic [31:0] server);
        logic [95:0] hdr;
        hdr = {len, client, server};
        for (int i = HEADER_BYTES - 1; i >= 0; i--)
            push_byte(hdr[8*i +: 8]);
    endtask

    // Header plus random payload; payload only follows when the length is accepted
    task automatic send_frame(input logic [31:0] len, input logic [31:0] client,
                              input logic [31:0] server);
        send_header(len, client, server);
        if (len != 32'd0 && len <= {11'd0, max_len}) begin
            for (int unsigned k = 0; k < len; k++)
                push_byte(8'($urandom_range(255)));
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    // Reader: stall at random, drive pop on the falling edge
    always @(negedge i_clk) begin
        pop <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // Check every result transfer against the oldest owed result
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            t_rec want;
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d, frame_length 0x%0h", o_kind,
                       o_frame_length);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(o_kind));
                check_field("payload_byte", 32'(want.payload_byte), 32'(o_payload_byte));
                check_field("client_tag", want.client_tag, o_client_tag);
                check_field("server_tag", want.server_tag, o_server_tag);
                check_field("frame_length", want.frame_length, o_frame_length);
                check_field("last", 32'(want.last), 32'(o_last));
                case (want.kind)
                    KIND_PAYLOAD: n_payload++;
                    KIND_EMPTY:   n_empty++;
                    default:      n_drop++;
                endcase
            end
        end
    end

    // Reset value of the register: empty frame, two-byte frame with the byte
    // extremes, a length just past the limit, and an all-ones length.
    task automatic test_reset_limit();
        send_frame(32'd0, 32'hFFFF_FFFF, 32'h0000_0000);
        send_header(32'd2, 32'h0000_0000, 32'hFFFF_FFFF);
        push_byte(8'h00);
        push_byte(8'hFF);
        send_frame(32'd65537, 32'h1234_5678, 32'h9ABC_DEF0);
        send_frame(32'hFFFF_FFFF, 32'hA5A5_5A5A, 32'h5A5A_A5A5);
    endtask

    // Register extremes: zero drops everything but empty frames; the all-ones
    // register still drops one past it; a tiny limit accepts its own value.
    task automatic test_register_extremes();
        write_max_len('0);
        send_frame(32'd0, 32'h0000_0001, 32'h8000_0000);
        send_frame(32'd1, 32'h0000_0002, 32'h4000_0000);
        write_max_len('1);
        send_frame(32'd2097152, 32'h0000_0003, 32'h2000_0000);
        send_frame(32'd1, 32'h0000_0004, 32'h1000_0000);
        write_max_len(MAX_LEN_W'(3));
        send_frame(32'd3, 32'h0000_0005, 32'h0800_0000);
        send_frame(32'd4, 32'h0000_0006, 32'h0400_0000);
    endtask

    // Mostly well-formed frames with random ids and payload; the rest are
    // garbage headers, empty frames and oversize lengths. Pause halfway until
    // the reader has caught up.
    task automatic test_random_stream(input logic [MAX_LEN_W-1:0] limit, input int sidle,
                                      input int ridle, input int n_bytes);
        int          start;
        int          pick;
        bit          paused;
        logic [31:0] len;
        logic [31:0] cap;
        write_max_len(limit);
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        start  = bytes_pushed;
        paused = 1'b0;
        while (bytes_pushed - start < n_bytes) begin
            if (!paused && bytes_pushed - start > n_bytes / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(99);
            cap  = (max_len < 16) ? 32'(max_len) : 32'd16;
            if (pick < 10) begin
                // Garbage header: nonzero top byte makes it an oversize drop
                push_byte(8'($urandom_range(255, 1)));
                for (int i = 0; i < HEADER_BYTES - 1; i++)
                    push_byte(8'($urandom_range(255)));
            end else begin
                if (pick < 20)
                    len = 32'd0;
                else if (pick < 35)
                    len = $urandom_range(1) ? 32'(max_len) + 32'd1 + $urandom_range(3)
                                            : ($urandom | 32'h8000_0000);
                else if (pick < 40 && max_len <= 64)
                    len = 32'(max_len);
                else
                    len = (cap == 0) ? 32'd0 : $urandom_range(cap, 1);
                send_frame(len, $urandom, $urandom);
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 8;
        recv_idle_pct = 82;
        test_reset_limit();
        test_register_extremes();
        test_random_stream(MAX_LEN_W'(16), 8, 82, 130);
        test_random_stream(MAX_LEN_W'(1048576), 82, 8, 130);
        test_random_stream(MAX_LEN_W'(5), 0, 0, 130);
        wait_drained();

        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            errors++;
        end
        $display("Covered %0d pushed bytes: %0d payload, %0d empty-frame and %0d drop results",
                 bytes_pushed, n_payload, n_empty, n_drop);
        $display("Limits 0, 3, 5, 16, 65536, 1048576 and all-ones; stalls on either side");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
hdl/lpfd_pkg.sv
hdl/lpfd_front.sv
hdl/lpfd_queue.sv
hdl/lpfd_back.sv
hdl/length_prefixed_frame_deframer.sv
sim/testbench.sv
